[rtl/core/fec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fec_pkg;
    localparam int NUM_SETS = 5;
    localparam int DEG_BITS = 7;
    localparam logic [DEG_BITS-1:0] FULL_DEG = 7'd100;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;
    // degree unit: classify, scale, 7 quotient bits, final degree
    localparam int DEG_LAT = 10;
    // centroid unit: products, sums, magnitude, 16 quotient bits
    localparam int CEN_LAT = 19;

    localparam logic [CFG_IDX_BITS-1:0] REG_NEG_LARGE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NEG       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ZERO      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_POS       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_POS_LARGE = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CTR_LOW   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_CTR_HIGH  = 3'd6;
endpackage
`default_nettype wire

[rtl/core/fec_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface fec_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] setpoint;
    logic signed [15:0] measured;
    modport source (output valid, setpoint, measured, input ready);
    modport sink   (input valid, setpoint, measured, output ready);
endinterface

interface fec_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] control_value;
    logic               no_rule_fired;
    modport source (output valid, control_value, no_rule_fired, input ready);
    modport sink   (input valid, control_value, no_rule_fired, output ready);
endinterface
`default_nettype wire

[rtl/core/fec_degree.sv]
`timescale 1ns / 1ps
`default_nettype none
module fec_degree
    import fec_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic signed [16:0]  i_err,
    input  wire logic [63:0]         i_pts,
    output logic [DEG_BITS-1:0]      o_deg
);
    typedef enum logic [1:0] {M_ZERO, M_FULL, M_RISE, M_FALL} t_mode;

    localparam int NB = 16;
    localparam int RB = NB + DEG_BITS;

    logic signed [17:0] p0, p1, p2, p3, e;
    t_mode              n_mode;
    logic [17:0]        n_num_w, n_den_w;

    t_mode              r_mode_b;
    logic [NB-1:0]      r_num_b, r_den_b;
    t_mode              r_mode_c;
    logic [RB-1:0]      r_num_c;
    logic [NB-1:0]      r_den_c;
    t_mode              r_mode [DEG_BITS];
    logic [RB-1:0]      r_rem  [DEG_BITS];
    logic [NB-1:0]      r_den  [DEG_BITS];
    logic [DEG_BITS-1:0] r_q   [DEG_BITS];
    logic [DEG_BITS-1:0] r_deg;

    always_comb begin
        p0 = 18'(signed'(i_pts[15:0]));
        p1 = 18'(signed'(i_pts[31:16]));
        p2 = 18'(signed'(i_pts[47:32]));
        p3 = 18'(signed'(i_pts[63:48]));
        e  = 18'(i_err);
        n_mode  = M_ZERO;
        n_num_w = '0;
        n_den_w = '0;
        if (e < p0) begin
            n_mode = M_ZERO;
        end else if (e <= p1) begin
            n_mode  = (p0 == p1) ? M_FULL : M_RISE;
            n_num_w = e - p0;
            n_den_w = p1 - p0;
        end else if (e <= p2) begin
            n_mode = M_FULL;
        end else if (e <= p3) begin
            n_mode  = (p2 == p3) ? M_FULL : M_FALL;
            n_num_w = e - p2;
            n_den_w = p3 - p2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mode_b <= n_mode;
            r_num_b  <= n_num_w[NB-1:0];
            r_den_b  <= n_den_w[NB-1:0];
            r_mode_c <= r_mode_b;
            r_num_c  <= RB'(r_num_b) * RB'(FULL_DEG);
            r_den_c  <= r_den_b;
            for (int j = 0; j < DEG_BITS; j++) begin
                logic [RB-1:0]       rem_in;
                logic [NB-1:0]       den_in;
                logic [DEG_BITS-1:0] q_in;
                t_mode               mode_in;
                logic [RB-1:0]       sub;
                if (j == 0) begin
                    rem_in  = r_num_c;
                    den_in  = r_den_c;
                    q_in    = '0;
                    mode_in = r_mode_c;
                end else begin
                    rem_in  = r_rem[j-1];
                    den_in  = r_den[j-1];
                    q_in    = r_q[j-1];
                    mode_in = r_mode[j-1];
                end
                sub = RB'(den_in) << (DEG_BITS - 1 - j);
                r_mode[j] <= mode_in;
                r_den[j]  <= den_in;
                if (rem_in >= sub) begin
                    r_rem[j] <= rem_in - sub;
                    r_q[j]   <= q_in | (DEG_BITS'(1) << (DEG_BITS - 1 - j));
                end else begin
                    r_rem[j] <= rem_in;
                    r_q[j]   <= q_in;
                end
            end
            case (r_mode[DEG_BITS-1])
                M_ZERO:  r_deg <= '0;
                M_FULL:  r_deg <= FULL_DEG;
                M_RISE:  r_deg <= r_q[DEG_BITS-1];
                M_FALL:  r_deg <= FULL_DEG - r_q[DEG_BITS-1];
                default: r_deg <= '0;
            endcase
        end
    end

    assign o_deg = r_deg;
endmodule
`default_nettype wire

[rtl/core/fec_centroid.sv]
`timescale 1ns / 1ps
`default_nettype none
module fec_centroid
    import fec_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [DEG_BITS-1:0] i_deg [NUM_SETS],
    input  wire logic signed [15:0]  i_ctr [NUM_SETS],
    output logic [15:0]              o_mag,
    output logic                     o_neg,
    output logic                     o_none
);
    localparam int QB = 16;
    localparam int PB = DEG_BITS + 1 + 16;
    localparam int SB = PB + 3;
    localparam int DB = 9;
    localparam int AB = 24;

    logic signed [PB-1:0] r_prod [NUM_SETS];
    logic [DEG_BITS-1:0]  r_dg   [NUM_SETS];
    logic signed [SB-1:0] r_sum;
    logic [DB-1:0]        r_dsum;
    logic [AB-1:0]        r_abs;
    logic                 r_neg_m, r_none_m;
    logic [DB-1:0]        r_den_m;
    logic [AB-1:0]        r_rem  [QB];
    logic [DB-1:0]        r_den  [QB];
    logic [QB-1:0]        r_q    [QB];
    logic                 r_neg  [QB];
    logic                 r_none [QB];

    logic signed [SB-1:0] n_sum;
    logic [DB-1:0]        n_dsum;
    logic [SB-1:0]        n_abs;

    always_comb begin
        n_sum  = '0;
        n_dsum = '0;
        for (int k = 0; k < NUM_SETS; k++) begin
            n_sum  = n_sum + SB'(r_prod[k]);
            n_dsum = n_dsum + DB'(r_dg[k]);
        end
        n_abs = r_sum[SB-1] ? SB'(-r_sum) : SB'(r_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_SETS; k++) begin
                r_prod[k] <= $signed(PB'({1'b0, i_deg[k]})) * PB'(i_ctr[k]);
                r_dg[k]   <= i_deg[k];
            end
            r_sum    <= n_sum;
            r_dsum   <= n_dsum;
            r_abs    <= n_abs[AB-1:0];
            r_neg_m  <= r_sum[SB-1];
            r_none_m <= (r_dsum == '0);
            r_den_m  <= r_dsum;
            for (int j = 0; j < QB; j++) begin
                logic [AB-1:0] rem_in;
                logic [DB-1:0] den_in;
                logic [QB-1:0] q_in;
                logic          neg_in, none_in;
                logic [AB-1:0] sub;
                if (j == 0) begin
                    rem_in  = r_abs;
                    den_in  = r_den_m;
                    q_in    = '0;
                    neg_in  = r_neg_m;
                    none_in = r_none_m;
                end else begin
                    rem_in  = r_rem[j-1];
                    den_in  = r_den[j-1];
                    q_in    = r_q[j-1];
                    neg_in  = r_neg[j-1];
                    none_in = r_none[j-1];
                end
                sub = AB'(den_in) << (QB - 1 - j);
                r_den[j]  <= den_in;
                r_neg[j]  <= neg_in;
                r_none[j] <= none_in;
                if (!none_in && rem_in >= sub) begin
                    r_rem[j] <= rem_in - sub;
                    r_q[j]   <= q_in | (QB'(1) << (QB - 1 - j));
                end else begin
                    r_rem[j] <= rem_in;
                    r_q[j]   <= q_in;
                end
            end
        end
    end

    assign o_mag  = r_q[QB-1];
    assign o_neg  = r_neg[QB-1];
    assign o_none = r_none[QB-1];
endmodule
`default_nettype wire

[rtl/core/fuzzy_error_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | payload
// i_in    | in        | setpoint, measured (signed 16-bit mV)
// o_out   | out       | control_value (signed 16-bit mV), no_rule_fired
// i_cfg_* | in        | write enable, 3-bit index, 64-bit data
//
// one beat per cycle sustained while the output is not stalled; stages from accept to output valid:
// error register at accept, then 10-stage degree units, 19-stage centroid unit,
// output register
// synchronous active-low reset clears valid bits and configuration
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
module fuzzy_error_controller
    import fec_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    fec_in_if.sink                        i_in,
    fec_out_if.source                     o_out,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);
    localparam int LAT = 1 + DEG_LAT + CEN_LAT;

    logic [63:0]        r_pts [NUM_SETS];
    logic [47:0]        r_ctr_lo;
    logic [31:0]        r_ctr_hi;
    logic [LAT-1:0]     r_vld;
    logic signed [16:0] r_err;
    logic               r_out_vld;
    logic signed [15:0] r_out_val;
    logic               r_out_none;

    logic                en;
    logic [DEG_BITS-1:0] deg [NUM_SETS];
    logic signed [15:0]  ctr [NUM_SETS];
    logic [15:0]         mag;
    logic                neg, none;

    assign en          = !r_out_vld || o_out.ready;
    assign i_in.ready  = en;

    assign ctr[0] = r_ctr_lo[15:0];
    assign ctr[1] = r_ctr_lo[31:16];
    assign ctr[2] = r_ctr_lo[47:32];
    assign ctr[3] = r_ctr_hi[15:0];
    assign ctr[4] = r_ctr_hi[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SETS; k++) r_pts[k] <= '0;
            r_ctr_lo <= '0;
            r_ctr_hi <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NEG_LARGE: r_pts[0] <= i_cfg_data;
                REG_NEG:       r_pts[1] <= i_cfg_data;
                REG_ZERO:      r_pts[2] <= i_cfg_data;
                REG_POS:       r_pts[3] <= i_cfg_data;
                REG_POS_LARGE: r_pts[4] <= i_cfg_data;
                REG_CTR_LOW:   r_ctr_lo <= i_cfg_data[47:0];
                REG_CTR_HIGH:  r_ctr_hi <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[LAT-2:0], i_in.valid};
            r_out_vld <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_err      <= 17'(i_in.setpoint) - 17'(i_in.measured);
            r_out_none <= none;
            r_out_val  <= none ? 16'sd0 : (neg ? -$signed(mag) : $signed(mag));
        end
    end

    for (genvar k = 0; k < NUM_SETS; k++) begin : g_set
        fec_degree u_deg (
            .i_clk (i_clk),
            .i_en  (en),
            .i_err (r_err),
            .i_pts (r_pts[k]),
            .o_deg (deg[k])
        );
    end

    fec_centroid u_cen (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_deg  (deg),
        .i_ctr  (ctr),
        .o_mag  (mag),
        .o_neg  (neg),
        .o_none (none)
    );

    assign o_out.valid         = r_out_vld;
    assign o_out.control_value = r_out_val;
    assign o_out.no_rule_fired = r_out_none;
endmodule
`default_nettype wire
